FILE: rtl/text_mode_terminal_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text-mode terminal writer
// Concurrent checks on the rising edge of clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_MODE_TERMINAL_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge out of reset.
`define TMTW_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define TMTW_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define TMTW_ASSERT_ALWAYS(label, cond, msg)
`define TMTW_ASSERT_IMPLIES(label, ante, cons, msg)

`endif

`endif

FILE: rtl/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared constants, codes and helpers of the text-mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

	// Default screen geometry.
	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	// Fixed field widths of the request, response and configuration channels.
	localparam int OP_W       = 2;
	localparam int CHAR_W     = 8;
	localparam int IDX_W      = 11;
	localparam int CELL_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// Control characters.
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;
	localparam logic [3:0] FG_RESET = 4'h7;
	localparam logic [2:0] BG_RESET = 3'h0;

	localparam logic [7:0]        RESET_ATTR = 8'h07;
	localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

	// Side effects of one byte on the screen, as seen by the sequencer.
	typedef struct packed {
		logic store_en;
		logic scroll;
	} move_flags_t;

	// Attribute byte: blink bit clear, background in 6..4, foreground in 3..0.
	function automatic logic [7:0] make_attr(input logic [3:0] fg, input logic [2:0] bg);
		return {1'b0, bg, fg};
	endfunction

	function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] attr,
		input logic [CHAR_W-1:0] ch);
		return {attr, ch};
	endfunction

endpackage

FILE: rtl/tmtw_if.sv
// ----------------------------------------------------------------------------
// Channel interfaces of the text-mode terminal writer
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tmtw_req_if;
	import tmtw_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;
	logic              last_byte;

	modport source (output valid, operation, char_code, cell_index, last_byte, input ready);
	modport sink   (input valid, operation, char_code, cell_index, last_byte, output ready);
endinterface

interface tmtw_rsp_if;
	import tmtw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CELL_W-1:0] cell_value;
	logic [IDX_W-1:0]  cursor_position;

	modport source (output valid, cell_value, cursor_position, input ready);
	modport sink   (input valid, cell_value, cursor_position, output ready);
endinterface

interface tmtw_cfg_if;
	import tmtw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/text_mode_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Text console engine: a character-cell screen store with cursor handling,
// scrolling, cell reads and screen clear.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Fields                                   Transfer
//   req      in   operation, char_code, cell_index,        valid & ready
//                 last_byte
//   rsp      out  cell_value, cursor_position              valid & ready
//   cfg      in   index, data (0 foreground, 1 background) valid & ready
//
// A byte write that does not scroll runs through an execute state and
// returns to idle; its result is registered as that state ends, or waits
// in a done state while the output register is still full. A cell read adds
// a read state, since the screen memory returns data in the cycle after the
// address. A write that runs past the bottom row goes on to copy the rows up
// through the memory and then to blank the last row.
// A clear blanks every cell, one memory write per cycle.
// After reset the screen store is swept to blanks; no request is taken
// during the sweep, configuration writes are.
// A new request is taken while the previous result still waits on rsp.
// ----------------------------------------------------------------------------
`include "text_mode_terminal_writer_assert.svh"

module text_mode_terminal_writer #(
	parameter int COLUMNS  = tmtw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tmtw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tmtw_pkg::TAB_STOP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tmtw_req_if.sink   req,
	tmtw_rsp_if.source rsp,
	tmtw_cfg_if.sink   cfg
);
	import tmtw_pkg::*;

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_N     = CELL_COUNT - COLUMNS;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	// Sequencer states.
	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_READ   = 3'd3;
	localparam logic [2:0] S_SCROLL = 3'd4;
	localparam logic [2:0] S_BLANK  = 3'd5;
	localparam logic [2:0] S_CLEAR  = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	// Control state.
	logic [2:0]       state_q, st_d;
	logic [ADDR_W-1:0] cnt_q, cnt_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [IDX_W-1:0] cursor_reg_q, cursor_reg_d;
	logic [3:0]       fg_q;
	logic [2:0]       bg_q;
	logic             rsp_valid_q;
	logic             cp_valid_s1;

	// Payload registers of the request being worked on.
	logic [OP_W-1:0]   op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;
	logic              rd_ok_q;
	logic [CELL_W-1:0] pend_q;
	logic [CELL_W-1:0] cell_value_q;
	logic [IDX_W-1:0]  cursor_position_q;
	logic [ADDR_W-1:0] cp_addr_s1;

	// Screen memory and its ports.
	logic [CELL_W-1:0] mem [CELL_COUNT];
	logic [CELL_W-1:0] rd_data_s1;
	logic              we, re;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [CELL_W-1:0] wdata;

	logic              req_acc;
	logic              out_free;
	logic              fin;
	logic [CELL_W-1:0] fin_value;
	logic              cp_issue;
	logic              cnt_last;
	logic [7:0]        attr;
	logic [CELL_W-1:0] blank_cell;

	logic [ADDR_W+IDX_W-1:0] cidx_wide;
	logic                    rd_ok;

	// Cursor interpretation of the byte held for execution.
	move_flags_t       mv_flags;
	logic [ROW_W-1:0]  mv_row;
	logic [COL_W-1:0]  mv_col;
	logic [ADDR_W-1:0] mv_addr;
	logic [CHAR_W-1:0] mv_char;
	logic [IDX_W-1:0]  mv_pos;

	tmtw_cursor #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_cursor (
		.row        (row_q),
		.col        (col_q),
		.char_code  (ch_q),
		.flags      (mv_flags),
		.row_nx     (mv_row),
		.col_nx     (mv_col),
		.store_addr (mv_addr),
		.store_char (mv_char),
		.pos_nx     (mv_pos)
	);

	assign req.ready  = (state_q == S_IDLE);
	assign req_acc    = req.valid && req.ready;
	assign cfg.ready  = 1'b1;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.cell_value      = cell_value_q;
	assign rsp.cursor_position = cursor_position_q;

	// The output register is free when empty or emptied in this cycle.
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign cnt_last   = (cnt_q == ADDR_W'(CELL_COUNT - 1));
	assign attr       = make_attr(fg_q, bg_q);
	assign blank_cell = make_cell(attr, BLANK_CHAR);

	// Reads beyond the screen return zero and leave the memory alone.
	assign cidx_wide  = (ADDR_W+IDX_W)'(idx_q);
	assign rd_ok      = (cidx_wide < (ADDR_W+IDX_W)'(CELL_COUNT));

	// The cursor register takes the new cursor on a marked byte write.
	assign cursor_reg_d = (state_q == S_EXEC && op_q == OP_WRITE && last_q) ?
		mv_pos : cursor_reg_q;

	// Sequencer: memory port control, next state and result completion.
	always_comb begin
		st_d      = state_q;
		cnt_d     = cnt_q;
		row_d     = row_q;
		col_d     = col_q;
		fin       = 1'b0;
		fin_value = '0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = '0;
		re        = 1'b0;
		raddr     = '0;
		cp_issue  = 1'b0;
		case (state_q)
			S_INIT: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = RESET_CELL;
				if (cnt_last) begin
					st_d  = S_IDLE;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + ADDR_W'(1);
				end
			end
			S_IDLE: begin
				if (req_acc) begin
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q)
					OP_WRITE: begin
						we    = mv_flags.store_en;
						waddr = mv_addr;
						wdata = make_cell(attr, mv_char);
						row_d = mv_row;
						col_d = mv_col;
						if (mv_flags.scroll) begin
							st_d  = S_SCROLL;
							cnt_d = '0;
						end else begin
							fin = 1'b1;
						end
					end
					OP_READ: begin
						re    = rd_ok;
						raddr = cidx_wide[ADDR_W-1:0];
						st_d  = S_READ;
					end
					OP_CLEAR: begin
						row_d = '0;
						col_d = '0;
						cnt_d = '0;
						st_d  = S_CLEAR;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_READ: begin
				fin       = 1'b1;
				fin_value = rd_ok_q ? rd_data_s1 : '0;
			end
			S_SCROLL: begin
				// Read one row ahead and write each word back once it is registered;
				// the write address always trails the read address.
				if (cnt_q != ADDR_W'(COPY_N)) begin
					re       = 1'b1;
					raddr    = cnt_q + ADDR_W'(COLUMNS);
					cp_issue = 1'b1;
					cnt_d    = cnt_q + ADDR_W'(1);
				end else begin
					st_d = S_BLANK;
				end
				if (cp_valid_s1) begin
					we    = 1'b1;
					waddr = cp_addr_s1;
					wdata = rd_data_s1;
				end
			end
			S_BLANK, S_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = blank_cell;
				if (cnt_last) begin
					fin   = 1'b1;
					cnt_d = '0;
				end else begin
					cnt_d = cnt_q + ADDR_W'(1);
				end
			end
			S_DONE: begin
				fin       = 1'b1;
				fin_value = pend_q;
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
		if (fin) begin
			st_d = out_free ? S_IDLE : S_DONE;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			cursor_reg_q <= '0;
			fg_q         <= FG_RESET;
			bg_q         <= BG_RESET;
			rsp_valid_q  <= 1'b0;
			cp_valid_s1  <= 1'b0;
		end else begin
			state_q      <= st_d;
			cnt_q        <= cnt_d;
			row_q        <= row_d;
			col_q        <= col_d;
			cursor_reg_q <= cursor_reg_d;
			cp_valid_s1  <= cp_issue;
			if (fin && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					CFG_FG:  fg_q <= cfg.data[3:0];
					CFG_BG:  bg_q <= cfg.data[2:0];
					default: ;
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q   <= req.operation;
			ch_q   <= req.char_code;
			idx_q  <= req.cell_index;
			last_q <= req.last_byte;
		end
		if (state_q == S_EXEC) begin
			rd_ok_q <= rd_ok;
		end
		if (cp_issue) begin
			cp_addr_s1 <= cnt_q;
		end
		if (fin && !out_free) begin
			pend_q <= fin_value;
		end
		if (fin && out_free) begin
			cell_value_q      <= fin_value;
			cursor_position_q <= cursor_reg_d;
		end
	end

	// Screen memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_data_s1 <= mem[raddr];
		end
	end

	// The row copy never reads the entry it writes in the same cycle.
	`TMTW_ASSERT_IMPLIES(a_scroll_no_overlap, we && re, waddr != raddr,
		"screen memory read and write hit the same entry")
	// The cursor always stays on the screen.
	`TMTW_ASSERT_ALWAYS(a_row_range, row_q <= ROW_W'(ROWS - 1), "cursor row out of range")
	`TMTW_ASSERT_ALWAYS(a_col_range, col_q <= COL_W'(COLUMNS - 1),
		"cursor column out of range")
	// Every memory write lands inside the screen.
	`TMTW_ASSERT_IMPLIES(a_waddr_range, we, waddr <= ADDR_W'(CELL_COUNT - 1),
		"screen memory write beyond the last cell")

endmodule

FILE: rtl/tmtw_cursor.sv
// ----------------------------------------------------------------------------
// tmtw_cursor
// Interprets one byte against the cursor: next row and column, the cell to
// store and whether the screen has to scroll.
// ----------------------------------------------------------------------------
module tmtw_cursor #(
	parameter int COLUMNS  = tmtw_pkg::COLUMNS_DEF,
	parameter int ROWS     = tmtw_pkg::ROWS_DEF,
	parameter int TAB_STOP = tmtw_pkg::TAB_STOP_DEF,
	localparam int ROW_W   = $clog2(ROWS),
	localparam int COL_W   = $clog2(COLUMNS),
	localparam int ADDR_W  = $clog2(ROWS * COLUMNS)
) (
	input  logic [ROW_W-1:0]              row,
	input  logic [COL_W-1:0]              col,
	input  logic [tmtw_pkg::CHAR_W-1:0]   char_code,
	output tmtw_pkg::move_flags_t         flags,
	output logic [ROW_W-1:0]              row_nx,
	output logic [COL_W-1:0]              col_nx,
	output logic [ADDR_W-1:0]             store_addr,
	output logic [tmtw_pkg::CHAR_W-1:0]   store_char,
	output logic [tmtw_pkg::IDX_W-1:0]    pos_nx
);
	import tmtw_pkg::*;

	// Next tab stop for every column, and whether it falls off the row.
	logic [COL_W-1:0] tab_col [COLUMNS];
	logic             tab_wrap [COLUMNS];

	for (genvar c = 0; c < COLUMNS; c++) begin : g_tab
		localparam int NEXT_STOP = ((c / TAB_STOP) + 1) * TAB_STOP;
		assign tab_col[c]  = (NEXT_STOP >= COLUMNS) ? '0 : COL_W'(NEXT_STOP);
		assign tab_wrap[c] = (NEXT_STOP >= COLUMNS);
	end

	logic [ROW_W:0]          row_t;
	logic [COL_W-1:0]        col_t;
	logic [ROW_W-1:0]        srow;
	logic [COL_W-1:0]        scol;
	logic [ADDR_W-1:0]       pos_addr;
	logic [ADDR_W+IDX_W-1:0] pos_wide;
	logic                    store_en;
	logic                    scroll;

	always_comb begin
		row_t      = {1'b0, row};
		col_t      = col;
		srow       = row;
		scol       = col;
		store_en   = 1'b0;
		store_char = char_code;
		case (char_code)
			CH_NEWLINE: begin
				col_t = '0;
				row_t = {1'b0, row} + (ROW_W+1)'(1);
			end
			CH_TAB: begin
				if (tab_wrap[col]) begin
					col_t = '0;
					row_t = {1'b0, row} + (ROW_W+1)'(1);
				end else begin
					col_t = tab_col[col];
				end
			end
			CH_BACKSPACE: begin
				if (col != '0) begin
					col_t = col - COL_W'(1);
				end else if (row != '0) begin
					row_t = {1'b0, row} - (ROW_W+1)'(1);
					col_t = COL_W'(COLUMNS - 1);
				end
				// The blank goes under the cursor after it has stepped back.
				srow       = row_t[ROW_W-1:0];
				scol       = col_t;
				store_en   = 1'b1;
				store_char = BLANK_CHAR;
			end
			default: begin
				store_en = 1'b1;
				if (col == COL_W'(COLUMNS - 1)) begin
					col_t = '0;
					row_t = {1'b0, row} + (ROW_W+1)'(1);
				end else begin
					col_t = col + COL_W'(1);
				end
			end
		endcase
	end

	assign scroll       = (row_t == (ROW_W+1)'(ROWS));
	assign flags        = '{store_en: store_en, scroll: scroll};
	assign row_nx       = scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];
	assign col_nx       = col_t;
	assign store_addr   = ADDR_W'(srow) * ADDR_W'(COLUMNS) + ADDR_W'(scol);
	assign pos_addr     = ADDR_W'(row_nx) * ADDR_W'(COLUMNS) + ADDR_W'(col_nx);
	assign pos_wide     = (ADDR_W+IDX_W)'(pos_addr);
	assign pos_nx       = pos_wide[IDX_W-1:0];

endmodule

FILE: dv/text_mode_terminal_writer_tb.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_tb
// Self-checking testbench for the text-mode terminal writer. The testbench
// drives byte writes, cell reads, clears and no-op requests with random
// handshake gaps on both sides. A scoreboard keeps its own screen, cursor
// and color state, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tmtw_pkg::*;

	// Screen geometry matches the defaults that the block is built with.
	localparam int COLS  = COLUMNS_DEF;
	localparam int ROWS  = ROWS_DEF;
	localparam int TAB   = TAB_STOP_DEF;
	localparam int CELLS = COLS * ROWS;

	// Operation code 3 is unused by the block and must leave all state alone.
	localparam logic [OP_W-1:0] OP_NOP = 2'd3;

	localparam int unsigned NUM_PHASES   = 8;
	localparam int unsigned PHASE_ITEMS  = 200;
	localparam int unsigned HOLD_AT      = 300;
	localparam int unsigned HOLD_CYCLES  = 500;
	localparam int unsigned DRAIN_CYCLES = 64;
	// Worst case is every request scrolling the screen while both sides idle
	// for their longest gaps, plus the reset sweep and the long response hold;
	// the limit allows four times that.
	localparam int unsigned CYCLE_LIMIT  = 16_000_000;

	typedef struct {
		logic [OP_W-1:0]   operation;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
		logic              last_byte;
	} request_t;

	typedef struct {
		logic [CELL_W-1:0] cell_value;
		logic [IDX_W-1:0]  cursor_position;
	} response_t;

	// ------------------------------------------------------------------------
	// Screen scoreboard: a shadow of the screen store, cursor and colors.
	// Every accepted request updates the shadow and queues the response that
	// the block owes for it; every accepted response is checked against the
	// oldest queued one.
	// ------------------------------------------------------------------------
	class screen_scoreboard;
		logic [CELL_W-1:0] cells [CELLS];
		int unsigned       row;
		int unsigned       column;
		logic [IDX_W-1:0]  cursor_reg;
		logic [3:0]        fg;
		logic [2:0]        bg;
		response_t         awaited [$];
		int unsigned       mismatches;
		int unsigned       checked;
		int unsigned       scrolls;
		int unsigned       color_settings;
		int unsigned       op_count [4];

		function new();
			foreach (cells[i]) cells[i] = RESET_CELL;
			row = 0;
			column = 0;
			cursor_reg = '0;
			fg = FG_RESET;
			bg = BG_RESET;
			mismatches = 0;
			checked = 0;
			scrolls = 0;
			color_settings = 0;
			foreach (op_count[i]) op_count[i] = 0;
		endfunction

		function logic [7:0] attr();
			return {1'b0, bg, fg};
		endfunction

		function void set_color(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
			if (index == CFG_FG) begin
				fg = data;
			end else begin
				bg = data[2:0];
			end
		endfunction

		function void note_request(input request_t r);
			response_t res;
			int i;
			res.cell_value = '0;
			op_count[r.operation]++;
			case (r.operation)
				OP_WRITE: begin
					case (r.char_code)
						CH_NEWLINE: begin
							column = 0;
							row++;
						end
						CH_TAB: begin
							column = (column / TAB + 1) * TAB;
							if (column >= COLS) begin
								column = 0;
								row++;
							end
						end
						CH_BACKSPACE: begin
							// Steps back across a row boundary, but never past the
							// origin; the cell under the cursor is always blanked.
							if (column > 0) begin
								column--;
							end else if (row > 0) begin
								row--;
								column = COLS - 1;
							end
							cells[row * COLS + column] = {attr(), BLANK_CHAR};
						end
						default: begin
							cells[row * COLS + column] = {attr(), r.char_code};
							column++;
							if (column >= COLS) begin
								column = 0;
								row++;
							end
						end
					endcase
					if (row >= ROWS) begin
						for (i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
						for (i = CELLS - COLS; i < CELLS; i++) cells[i] = {attr(), BLANK_CHAR};
						row = ROWS - 1;
						scrolls++;
					end
					if (r.last_byte) cursor_reg = IDX_W'(row * COLS + column);
				end
				OP_READ: begin
					if (r.cell_index < CELLS) res.cell_value = cells[r.cell_index];
				end
				OP_CLEAR: begin
					foreach (cells[j]) cells[j] = {attr(), BLANK_CHAR};
					row = 0;
					column = 0;
				end
				default: begin
				end
			endcase
			res.cursor_position = cursor_reg;
			awaited.push_back(res);
		endfunction

		function void check_response(input response_t got);
			response_t want;
			if (awaited.size() == 0) begin
				$error("response with nothing outstanding: cell_value %h cursor_position %0d",
					got.cell_value, got.cursor_position);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			checked++;
			if (got.cell_value !== want.cell_value) begin
				$error("cell_value: expected %h, actual %h", want.cell_value, got.cell_value);
				mismatches++;
			end
			if (got.cursor_position !== want.cursor_position) begin
				$error("cursor_position: expected %0d, actual %0d",
					want.cursor_position, got.cursor_position);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tmtw_req_if req ();
	tmtw_rsp_if rsp ();
	tmtw_cfg_if cfg ();

	text_mode_terminal_writer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	screen_scoreboard sb;

	// Counts of real requests sent (no-ops excluded) and responses taken.
	int unsigned items_sent;
	int unsigned rx_count;
	int unsigned cycles;
	// Stretch counters: while one is nonzero that side runs without gaps.
	int unsigned tx_calm;
	int unsigned rx_calm;
	// Set while the response side holds off, so the sender pushes back to back.
	bit          rsp_hold;
	bit          hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Both monitors sample at the rising edge, before any of this edge's
	// nonblocking updates, so they see exactly the values that made the request.
	always @(posedge clk) begin
		if (arst_n && req.valid === 1'b1 && req.ready === 1'b1) begin
			sb.note_request('{req.operation, req.char_code, req.cell_index, req.last_byte});
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
			sb.check_response('{rsp.cell_value, rsp.cursor_position});
		end
	end

	// Draws the idle gap in front of one request or response. Now and then a
	// side enters a calm stretch where it never idles.
	function automatic int unsigned draw_gap(inout int unsigned calm);
		if (calm != 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	// Mostly arbitrary bytes, with the three control codes drawn more often
	// than their share of the byte range would give them.
	function automatic logic [CHAR_W-1:0] any_byte();
		case ($urandom_range(0, 11))
			0: return CH_NEWLINE;
			1: return CH_TAB;
			2: return CH_BACKSPACE;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Read addresses: anywhere on screen, around the cursor where recent text
	// landed, the bottom row that scrolling refills, or past the last cell.
	function automatic logic [IDX_W-1:0] pick_cell();
		int spot;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return IDX_W'($urandom_range(0, CELLS - 1));
			5, 6: begin
				spot = int'(sb.row * COLS + sb.column) - int'($urandom_range(0, 3));
				return (spot < 0) ? '0 : IDX_W'(spot);
			end
			7: return IDX_W'($urandom_range(CELLS - COLS, CELLS - 1));
			default: return IDX_W'($urandom_range(CELLS, (1 << IDX_W) - 1));
		endcase
	endfunction

	// Offers one request and returns at the edge where it is taken. The valid
	// line is only lowered when a gap follows, so back-to-back requests keep it
	// high without a second assignment in the same step.
	task automatic send(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
		input logic [IDX_W-1:0] idx, input logic last);
		int unsigned gap;
		gap = rsp_hold ? 0 : draw_gap(tx_calm);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.operation  <= op;
		req.char_code  <= ch;
		req.cell_index <= idx;
		req.last_byte  <= last;
		do @(posedge clk); while (req.ready !== 1'b1);
		if (op != OP_NOP) items_sent++;
	endtask

	// Drops valid after the last request of a batch and waits until every
	// response has come back, so the block is idle before colors change.
	// The extra edge lets the request monitor record the final request first.
	task automatic settle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	// Writes both color registers in a random order over the config channel.
	task automatic program_colors(input logic [CFG_DATA_W-1:0] fg_data,
		input logic [CFG_DATA_W-1:0] bg_data);
		bit fg_first;
		int k;
		logic [CFG_IDX_W-1:0] index;
		fg_first = 1'($urandom_range(0, 1));
		cfg.valid <= 1'b1;
		for (k = 0; k < 2; k++) begin
			index = ((k == 0) == fg_first) ? CFG_FG : CFG_BG;
			cfg.index <= index;
			cfg.data  <= (index == CFG_FG) ? fg_data : bg_data;
			do @(posedge clk); while (cfg.ready !== 1'b1);
			sb.set_color(index, (index == CFG_FG) ? fg_data : bg_data);
		end
		cfg.valid <= 1'b0;
		sb.color_settings++;
	endtask

	// One phase of random traffic. Most of it is well-formed strings that end
	// with the last-byte mark, so the cursor register tracks real text; the
	// rest is reads, cursor-motion runs, clears and unstructured noise.
	task automatic run_phase(input int unsigned quota);
		int unsigned start;
		int unsigned len;
		int unsigned pick;
		int unsigned k;
		bit broken;
		start = items_sent;
		while (items_sent - start < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// A string; one in five carries scattered last-byte marks.
				len = $urandom_range(1, 20);
				broken = ($urandom_range(0, 4) == 0);
				for (k = 0; k < len; k++) begin
					send(OP_WRITE, any_byte(), IDX_W'($urandom_range(0, 2047)),
						broken ? 1'($urandom_range(0, 1)) : (k == len - 1));
				end
			end else if (pick < 60) begin
				len = $urandom_range(1, 6);
				for (k = 0; k < len; k++) begin
					send(OP_READ, CHAR_W'($urandom_range(0, 255)), pick_cell(),
						1'($urandom_range(0, 1)));
				end
			end else if (pick < 68) begin
				// Newline runs push the cursor down to the bottom and scroll.
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++) begin
					send(OP_WRITE, CH_NEWLINE, IDX_W'($urandom_range(0, 2047)),
						k == len - 1);
				end
			end else if (pick < 72) begin
				send(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
					IDX_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
			end else if (pick < 80) begin
				len = $urandom_range(1, 10);
				for (k = 0; k < len; k++) begin
					send(OP_WRITE, CH_BACKSPACE, IDX_W'($urandom_range(0, 2047)),
						k == len - 1);
				end
			end else if (pick < 86) begin
				len = $urandom_range(1, 12);
				for (k = 0; k < len; k++) begin
					send(OP_WRITE, CH_TAB, IDX_W'($urandom_range(0, 2047)), k == len - 1);
				end
			end else if (pick < 95) begin
				send(OP_W'($urandom_range(0, 3)), any_byte(),
					IDX_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
			end else begin
				send(OP_NOP, CHAR_W'($urandom_range(0, 255)),
					IDX_W'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
			end
		end
		settle();
	endtask

	// Response side. Once, after a few hundred responses, it holds ready low
	// for a long stretch while the sender keeps offering requests, so the
	// block fills its output and has to stall the request channel.
	initial begin
		int unsigned wait_cycles;
		rsp.ready <= 1'b0;
		rx_calm = 0;
		rx_count = 0;
		rsp_hold = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && rx_count >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_hold = 1'b1;
				wait_cycles = HOLD_CYCLES;
			end else begin
				wait_cycles = draw_gap(rx_calm);
			end
			if (wait_cycles != 0) begin
				rsp.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_hold = 1'b0;
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
			rx_count++;
		end
	end

	// Watchdog: ends the run as a failure if the traffic never completes.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL text_mode_terminal_writer");
		$finish;
	end

	// Main sequence: reset, a directed pass over the corner cases with the
	// reset colors, then phases of random traffic under changing colors.
	initial begin
		int unsigned p;
		int unsigned k;
		sb = new();
		items_sent = 0;
		tx_calm = 0;
		arst_n         <= 1'b0;
		req.valid      <= 1'b0;
		req.operation  <= OP_WRITE;
		req.char_code  <= '0;
		req.cell_index <= '0;
		req.last_byte  <= 1'b0;
		cfg.valid      <= 1'b0;
		cfg.index      <= CFG_FG;
		cfg.data       <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reads of the swept screen, including both ends and out-of-range
		// addresses, which must read as zero.
		send(OP_READ, 8'h00, '0, 1'b0);
		send(OP_READ, 8'hFF, IDX_W'(CELLS - 1), 1'b1);
		send(OP_READ, 8'h00, IDX_W'(CELLS), 1'b0);
		send(OP_READ, 8'h00, '1, 1'b0);
		// Backspace at the origin stays put and blanks the first cell.
		send(OP_WRITE, CH_BACKSPACE, '0, 1'b1);
		// Ordinary bytes, the lowest and highest codes among them.
		send(OP_WRITE, 8'h41, '0, 1'b0);
		send(OP_WRITE, 8'hFF, '0, 1'b0);
		send(OP_WRITE, 8'h00, '0, 1'b1);
		// Tab to the next stop, then a backspace that blanks what followed.
		send(OP_WRITE, CH_TAB, '0, 1'b1);
		send(OP_WRITE, 8'h42, '0, 1'b0);
		send(OP_WRITE, CH_BACKSPACE, '0, 1'b1);
		// Newline, then backspace from column zero to the end of the row above.
		send(OP_WRITE, CH_NEWLINE, '0, 1'b1);
		send(OP_WRITE, CH_BACKSPACE, '0, 1'b1);
		// A tab from the last column wraps onto the next row.
		send(OP_WRITE, CH_TAB, '0, 1'b1);
		send(OP_WRITE, CH_BACKSPACE, '0, 1'b0);
		// An ordinary byte in the last column wraps as well.
		send(OP_WRITE, 8'h7E, '0, 1'b1);
		// The unused operation code and last-byte marks on reads change nothing.
		send(OP_NOP, 8'h55, 11'h2AA, 1'b1);
		send(OP_READ, 8'h00, IDX_W'(COLS - 1), 1'b1);
		send(OP_READ, 8'h00, 11'd1, 1'b0);
		// Clear keeps the cursor register but homes the cursor.
		send(OP_CLEAR, 8'h00, '0, 1'b1);
		send(OP_READ, 8'h00, IDX_W'(COLS - 1), 1'b0);
		send(OP_WRITE, 8'h5A, '0, 1'b0);
		send(OP_READ, 8'h00, '0, 1'b0);
		settle();

		for (p = 0; p < NUM_PHASES; p++) begin
			// The first two phases use the lowest and highest colors; later
			// ones draw full four-bit data so the unused background bit toggles.
			case (p)
				0: program_colors(4'h0, 4'h0);
				1: program_colors(4'hF, 4'h7);
				default: program_colors(CFG_DATA_W'($urandom_range(0, 15)),
					CFG_DATA_W'($urandom_range(0, 15)));
			endcase
			if (p == 0) begin
				// Drive the cursor to the bottom early so text scrolls soon.
				for (k = 0; k < 30; k++) begin
					send(OP_WRITE, CH_NEWLINE, IDX_W'($urandom_range(0, 2047)), k == 29);
				end
			end
			run_phase(PHASE_ITEMS);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d writes, %0d reads, %0d clears and %0d no-ops, with %0d scrolls.",
			sb.op_count[OP_WRITE], sb.op_count[OP_READ], sb.op_count[OP_CLEAR],
			sb.op_count[OP_NOP], sb.scrolls);
		$display("Checked %0d responses under %0d color settings.", sb.checked,
			sb.color_settings + 1);
		if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
			$display("PASS text_mode_terminal_writer");
		end else begin
			$display("FAIL text_mode_terminal_writer");
		end
		$finish;
	end

endmodule
